// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== hw/rtl/salc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package salc_pkg;

  localparam int unsigned AddrWidth = 64;
  localparam int unsigned CntWidth  = 32;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_STORE  = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;

  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_FILL  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  localparam logic [1:0] CFG_INDEX_BITS  = 2'd0;
  localparam logic [1:0] CFG_WAYS_IN_USE = 2'd1;
  localparam logic [1:0] CFG_OFFSET_BITS = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_e;

  // Saturating add of a small increment to a transaction total.
  function automatic logic [CntWidth-1:0] sat_add(logic [CntWidth-1:0] a, logic [1:0] inc);
    logic [CntWidth:0] sum;
    sum = {1'b0, a} + {{(CntWidth-1){1'b0}}, inc};
    return sum[CntWidth] ? {CntWidth{1'b1}} : sum[CntWidth-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/set_assoc_lru_cache_sim_core.sv =====
// Channel        Signals                                   Handshake
// access in      address_i, operation_i                    start_i high while busy_o low
// result out     outcome_o, extra_hit_o, *_total_o         done_o high for one cycle
// config write   cfg_idx_i, cfg_wdata_i                    cfg_we_i high
//
// An access scans k ways, one per cycle with the shared tag comparator, where k runs from
// 1 up to ways in use and the scan stops at a hit; an update state then precedes the result strobe.
// A new access is taken in the cycle that shows the previous result.
// After reset a clearing pass writes every set row once, with busy_o high.
// The receiver cannot stall; each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module set_assoc_lru_cache_sim_core #(
  parameter int unsigned MAX_SET_BITS = 6,
  parameter int unsigned MAX_WAYS     = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [63:0] address_i,
  input  wire logic [1:0]  operation_i,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [5:0]  cfg_wdata_i,
  output logic             done_o,
  output logic [1:0]       outcome_o,
  output logic             extra_hit_o,
  output logic [31:0]      hit_total_o,
  output logic [31:0]      miss_total_o,
  output logic [31:0]      eviction_total_o
);

  localparam int unsigned NumSets = 1 << MAX_SET_BITS;
  localparam int unsigned SetW    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned WayW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned AgeW    = WayW;
  localparam int unsigned CntW    = $clog2(MAX_WAYS + 1);
  localparam logic [SetW-1:0] LastSet = SetW'(NumSets - 1);
  localparam logic [AgeW-1:0] AgeMax  = AgeW'(MAX_WAYS - 1);
  localparam logic [CntW-1:0] WaysMax = CntW'(MAX_WAYS);

  typedef struct packed {
    logic                                vld;
    logic [AgeW-1:0]                     age;
    logic [salc_pkg::AddrWidth-1:0]      tag;
  } way_t;

  typedef way_t [MAX_WAYS-1:0] row_t;

  salc_pkg::state_e state_q, state_d;

  logic [2:0] index_bits_q;
  logic [3:0] ways_in_use_q;
  logic [5:0] offset_bits_q;

  row_t mem_q [NumSets];
  row_t rd_q;
  row_t new_row;
  logic            mem_we;
  logic [SetW-1:0] mem_waddr;
  row_t            mem_wdata;

  logic [SetW-1:0] clr_q, clr_d;
  logic [SetW-1:0] set_q, set_in;
  logic [63:0]     tag_q, tag_in;
  logic [1:0]      op_q;

  logic [WayW-1:0] wi_q, wi_d;
  logic            hit_found_q, hit_found_d;
  logic [WayW-1:0] hit_way_q, hit_way_d;
  logic            inv_found_q, inv_found_d;
  logic [WayW-1:0] inv_way_q, inv_way_d;
  logic [WayW-1:0] vic_way_q, vic_way_d;
  logic [AgeW-1:0] vic_age_q, vic_age_d;

  logic [31:0] hits_q, misses_q, evictions_q;
  logic [1:0]  outcome_q, outcome_d;
  logic        extra_q;
  logic        done_q;

  logic            accept;
  logic [3:0]      sb;
  logic [SetW-1:0] set_mask;
  logic [63:0]     shifted;
  logic [6:0]      tag_shift;
  logic [CntW-1:0] ways_eff;
  logic [WayW-1:0] last_way;
  way_t            cur;
  logic            cur_hit;
  logic [WayW-1:0] sel_way;
  logic            old_vld;
  logic [AgeW-1:0] old_age;
  logic            extra_d;
  logic [1:0]      hit_inc;

  assign accept = start_i && (state_q == salc_pkg::ST_IDLE);
  assign busy_o = (state_q != salc_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_bits_q  <= 3'd0;
      ways_in_use_q <= 4'd1;
      offset_bits_q <= 6'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        salc_pkg::CFG_INDEX_BITS:  index_bits_q  <= cfg_wdata_i[2:0];
        salc_pkg::CFG_WAYS_IN_USE: ways_in_use_q <= cfg_wdata_i[3:0];
        salc_pkg::CFG_OFFSET_BITS: offset_bits_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    sb        = ({1'b0, index_bits_q} > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS)
                                                           : {1'b0, index_bits_q};
    set_mask  = ~({SetW{1'b1}} << sb);
    shifted   = address_i >> offset_bits_q;
    set_in    = shifted[SetW-1:0] & set_mask;
    tag_shift = {1'b0, offset_bits_q} + {3'b000, sb};
    tag_in    = tag_shift[6] ? 64'd0 : (address_i >> tag_shift[5:0]);
    if (ways_in_use_q == 4'd0) begin
      ways_eff = CntW'(1);
    end else if ({1'b0, ways_in_use_q} > 5'(MAX_WAYS)) begin
      ways_eff = WaysMax;
    end else begin
      ways_eff = CntW'(ways_in_use_q);
    end
    last_way = WayW'(ways_eff - CntW'(1));
  end

  always_comb begin
    cur         = rd_q[wi_q];
    cur_hit     = cur.vld && (cur.tag == tag_q);
    wi_d        = wi_q;
    hit_found_d = hit_found_q;
    hit_way_d   = hit_way_q;
    inv_found_d = inv_found_q;
    inv_way_d   = inv_way_q;
    vic_way_d   = vic_way_q;
    vic_age_d   = vic_age_q;
    if (accept) begin
      wi_d        = '0;
      hit_found_d = 1'b0;
      inv_found_d = 1'b0;
    end else if (state_q == salc_pkg::ST_SCAN) begin
      wi_d = wi_q + WayW'(1);
      if (cur_hit) begin
        hit_found_d = 1'b1;
        hit_way_d   = wi_q;
      end
      if (!cur.vld && !inv_found_q) begin
        inv_found_d = 1'b1;
        inv_way_d   = wi_q;
      end
      if ((wi_q == '0) || (cur.age > vic_age_q)) begin
        vic_way_d = wi_q;
        vic_age_d = cur.age;
      end
    end
  end

  always_comb begin
    if (hit_found_q) begin
      sel_way   = hit_way_q;
      old_vld   = 1'b1;
      old_age   = rd_q[hit_way_q].age;
      outcome_d = salc_pkg::OUT_HIT;
    end else if (inv_found_q) begin
      sel_way   = inv_way_q;
      old_vld   = 1'b0;
      old_age   = '0;
      outcome_d = salc_pkg::OUT_FILL;
    end else begin
      sel_way   = vic_way_q;
      old_vld   = 1'b1;
      old_age   = vic_age_q;
      outcome_d = salc_pkg::OUT_EVICT;
    end
    for (int k = 0; k < MAX_WAYS; k++) begin
      new_row[k] = rd_q[k];
      if (WayW'(k) == sel_way) begin
        new_row[k].vld = 1'b1;
        new_row[k].age = '0;
        new_row[k].tag = hit_found_q ? rd_q[k].tag : tag_q;
      end else if (rd_q[k].vld && (!old_vld || (rd_q[k].age < old_age))
                   && (rd_q[k].age < AgeMax)) begin
        new_row[k].age = rd_q[k].age + AgeW'(1);
      end
    end
    extra_d = (op_q == salc_pkg::OP_MODIFY);
    hit_inc = {1'b0, hit_found_q} + {1'b0, extra_d};
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      salc_pkg::ST_CLEAR: begin
        clr_d = clr_q + SetW'(1);
        if (clr_q == LastSet) begin
          state_d = salc_pkg::ST_IDLE;
        end
      end
      salc_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = salc_pkg::ST_SCAN;
        end
      end
      salc_pkg::ST_SCAN: begin
        if (cur_hit || (wi_q == last_way)) begin
          state_d = salc_pkg::ST_UPDATE;
        end
      end
      salc_pkg::ST_UPDATE: begin
        state_d = salc_pkg::ST_IDLE;
      end
      default: begin
        state_d = salc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (state_q == salc_pkg::ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = (state_q == salc_pkg::ST_UPDATE);
      mem_waddr = set_q;
      mem_wdata = new_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_q <= mem_q[set_in];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= salc_pkg::ST_CLEAR;
      clr_q       <= '0;
      wi_q        <= '0;
      hit_found_q <= 1'b0;
      inv_found_q <= 1'b0;
      hits_q      <= '0;
      misses_q    <= '0;
      evictions_q <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      wi_q        <= wi_d;
      hit_found_q <= hit_found_d;
      inv_found_q <= inv_found_d;
      done_q      <= (state_q == salc_pkg::ST_UPDATE);
      if (state_q == salc_pkg::ST_UPDATE) begin
        hits_q      <= salc_pkg::sat_add(hits_q, hit_inc);
        misses_q    <= salc_pkg::sat_add(misses_q, {1'b0, !hit_found_q});
        evictions_q <= salc_pkg::sat_add(evictions_q,
                                         {1'b0, (outcome_d == salc_pkg::OUT_EVICT)});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hit_way_q <= hit_way_d;
    inv_way_q <= inv_way_d;
    vic_way_q <= vic_way_d;
    vic_age_q <= vic_age_d;
    if (accept) begin
      set_q <= set_in;
      tag_q <= tag_in;
      op_q  <= operation_i;
    end
    if (state_q == salc_pkg::ST_UPDATE) begin
      outcome_q <= outcome_d;
      extra_q   <= extra_d;
    end
  end

  assign done_o           = done_q;
  assign outcome_o        = outcome_q;
  assign extra_hit_o      = extra_q;
  assign hit_total_o      = hits_q;
  assign miss_total_o     = misses_q;
  assign eviction_total_o = evictions_q;

  `ASSERT_IMPL(a_done_when_idle, clk_i, rst_ni, done_o, !busy_o)
  `ASSERT_NEXT(a_accept_goes_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  `ASSERT_NEXT(a_update_strobes, clk_i, rst_ni, state_q == salc_pkg::ST_UPDATE, done_o)
  `ASSERT_IMPL(a_extra_counts_hit, clk_i, rst_ni, done_o && extra_hit_o, hit_total_o != 32'd0)

endmodule

`default_nettype wire
